[src/drdr_pkg.sv]
// ----------------------------------------------------------------------------
// Dirty-row display refresh package
// Shared widths, codes, defaults, queue entry type and color conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package drdr_pkg;

   localparam int COL_W      = 9;
   localparam int ROW_W      = 9;
   localparam int ARGB_W     = 32;
   localparam int OUT_KIND_W = 2;
   localparam int FB_ADDR_W  = 17;
   localparam int PIX565_W   = 16;
   localparam int COUNT_W    = 9;
   localparam int THR_W      = 9;

   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 320;
   localparam int MAX_BANDS_DEF     = 4;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 9'd240;

   localparam logic IN_PIXEL = 1'b0;
   localparam logic IN_END   = 1'b1;

   typedef enum logic [OUT_KIND_W-1:0] {
      OUT_WRITE = 2'd0,
      OUT_BAND  = 2'd1,
      OUT_FULL  = 2'd2
   } out_kind_type;

   // One queue entry: a framebuffer write or an end-of-draw marker.
   typedef struct packed {
      logic                 is_end;
      logic                 shadow_valid;
      logic [ROW_W-1:0]     row;
      logic [FB_ADDR_W-1:0] fb_address;
      logic [PIX565_W-1:0]  pixel565;
   } queue_entry_type;

   function automatic logic [PIX565_W-1:0] to565_swapped(input logic [ARGB_W-1:0] p);
      logic [PIX565_W-1:0] v;
      v = {p[23:19], p[15:10], p[7:3]};
      return {v[7:0], v[15:8]};
   endfunction

endpackage

`default_nettype wire

[src/drdr_req_if.sv]
// ----------------------------------------------------------------------------
// Draw item channel
// Valid/ready channel carrying one pixel or end-of-draw item.
// ----------------------------------------------------------------------------
`default_nettype none

interface drdr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [drdr_pkg::COL_W-1:0]    column;
   logic [drdr_pkg::ROW_W-1:0]    row;
   logic [drdr_pkg::ARGB_W-1:0]   pixel_argb;

   modport source (output valid, kind, column, row, pixel_argb, input ready);
   modport sink   (input valid, kind, column, row, pixel_argb, output ready);
endinterface

`default_nettype wire

[src/drdr_rsp_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying framebuffer writes and refresh commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface drdr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [drdr_pkg::OUT_KIND_W-1:0]   out_kind;
   logic [drdr_pkg::FB_ADDR_W-1:0]    fb_address;
   logic [drdr_pkg::PIX565_W-1:0]     pixel565;
   logic [drdr_pkg::ROW_W-1:0]        first_row;
   logic [drdr_pkg::COUNT_W-1:0]      row_count;
   logic                              new_window;
   logic                              last;

   modport source (output valid, out_kind, fb_address, pixel565, first_row, row_count,
                   new_window, last, input ready);
   modport sink   (input valid, out_kind, fb_address, pixel565, first_row, row_count,
                   new_window, last, output ready);
endinterface

`default_nettype wire

[src/drdr_csr_if.sv]
// ----------------------------------------------------------------------------
// Threshold write channel
// Valid/ready channel carrying the full-refresh threshold.
// ----------------------------------------------------------------------------
`default_nettype none

interface drdr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [drdr_pkg::THR_W-1:0]    data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[src/dirty_row_display_refresh.sv]
// ----------------------------------------------------------------------------
// Dirty-row display refresh
// Shadow-compared framebuffer writes with banded or full panel refreshes.
// ----------------------------------------------------------------------------
// Usage:
//  req_port  takes draw items: pixels (kind 0) with column, row and ARGB color,
//            then one end-of-draw item (kind 1). One pixel per cycle if ready.
//  rsp_port  gives framebuffer writes (byte-swapped RGB565) for changed pixels
//            and, at end of draw, one full refresh or one band refresh per run
//            of dirty rows; last marks the final result of an item.
//  csr_port  writes the full-refresh threshold; always ready.
// Path: a pixel's write is registered in stage one, in the queue and in the
//  output register before it is valid on rsp_port.
// Throughput: one pixel per cycle while the queue has room, set by the single
//  read port of the shadow RAM. After the first draw an end of draw occupies
//  the refresh engine while it takes it and scans the dirty map, then while it
//  sends the refreshes; the front end keeps taking pixels into the queue
//  meanwhile until it fills.
// Reset: the shadow RAM is swept to all ones, SCREEN_WIDTH*SCREEN_HEIGHT
//  entries (102400 by default), with req_port not ready; the dirty map is
//  cleared meanwhile; threshold goes to 240.
// Stall: a held rsp_port backs up the queue and then drops req_port ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_row_display_refresh #(
   parameter int SCREEN_WIDTH  = drdr_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = drdr_pkg::SCREEN_HEIGHT_DEF,
   parameter int MAX_BANDS     = drdr_pkg::MAX_BANDS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   drdr_req_if.sink   req_port,
   drdr_rsp_if.source rsp_port,
   drdr_csr_if.sink   csr_port
);

   logic [drdr_pkg::THR_W-1:0] threshold_ff;
   logic                       push_valid;
   drdr_pkg::queue_entry_type  push_entry;
   logic                       fifo_full;
   logic                       pop;
   logic                       head_valid;
   drdr_pkg::queue_entry_type  head;

   // Threshold register: take every write transfer.
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= drdr_pkg::THRESHOLD_RESET;
      end else if (csr_port.valid) begin
         threshold_ff <= csr_port.data;
      end
   end

   // Front end: screen check, shadow compare, color conversion.
   drdr_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .fifo_full  (fifo_full)
   );

   // Queue decouples pixel intake from the row scan.
   drdr_fifo #(
      .DEPTH (drdr_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Refresh engine: dirty map, band scan, window tracking, output register.
   drdr_back #(
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .MAX_BANDS     (MAX_BANDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .threshold  (threshold_ff),
      .rsp_port   (rsp_port)
   );

endmodule

`default_nettype wire

[src/drdr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drdr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/drdr_front.sv]
// ----------------------------------------------------------------------------
// Draw front end
// Accepts items, compares pixels with the shadow copy, queues writes and ends.
// ----------------------------------------------------------------------------
`default_nettype none

module drdr_front #(
   parameter int SCREEN_WIDTH  = drdr_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = drdr_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   drdr_req_if.sink                       req_port,
   output logic                           push_valid,
   output drdr_pkg::queue_entry_type      push_entry,
   input  wire logic                      fifo_full
);

   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                        clearing_ff;
   logic [ADDR_W-1:0]           clear_addr_ff;
   logic                        shadow_valid_ff;
   logic                        s1_valid_ff;
   logic                        s1_end_ff;
   logic [ADDR_W-1:0]           s1_addr_ff;
   logic [drdr_pkg::ARGB_W-1:0] s1_argb_ff;
   logic [drdr_pkg::ROW_W-1:0]  s1_row_ff;
   logic                        s1_fwd_ff;
   logic [drdr_pkg::ARGB_W-1:0] s1_fwd_data_ff;

   logic                        s1_advance;
   logic                        accept;
   logic                        on_screen;
   logic                        take;
   logic [ADDR_W-1:0]           addr_calc;
   logic [drdr_pkg::ARGB_W-1:0] ram_q;
   logic [drdr_pkg::ARGB_W-1:0] current;
   logic                        changed;
   logic                        ram_wr_en;
   logic [ADDR_W-1:0]           ram_wr_addr;
   logic [drdr_pkg::ARGB_W-1:0] ram_wr_data;

   assign s1_advance     = !s1_valid_ff || !fifo_full;
   assign req_port.ready = !clearing_ff && s1_advance;
   assign accept         = req_port.valid && req_port.ready;
   assign on_screen      = (req_port.column < SCREEN_WIDTH) && (req_port.row < SCREEN_HEIGHT);
   assign take           = accept && ((req_port.kind == drdr_pkg::IN_END) || on_screen);
   assign addr_calc      = ADDR_W'(req_port.row) * ADDR_W'(SCREEN_WIDTH)
                         + ADDR_W'(req_port.column);

   // Forward the pixel that left stage one at issue time; the RAM returns stale data.
   assign current = s1_fwd_ff ? s1_fwd_data_ff : ram_q;
   assign changed = !shadow_valid_ff || (current != s1_argb_ff);

   assign push_valid = s1_valid_ff && !fifo_full && (s1_end_ff || changed);

   always_comb begin
      push_entry.is_end       = s1_end_ff;
      push_entry.shadow_valid = shadow_valid_ff;
      push_entry.row          = s1_row_ff;
      push_entry.fb_address   = drdr_pkg::FB_ADDR_W'(s1_addr_ff);
      push_entry.pixel565     = drdr_pkg::to565_swapped(s1_argb_ff);
   end

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '1;
      end else begin
         ram_wr_en   = push_valid && !s1_end_ff;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = s1_argb_ff;
      end
   end

   drdr_ram #(
      .WIDTH (drdr_pkg::ARGB_W),
      .DEPTH (DEPTH)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (take && (req_port.kind == drdr_pkg::IN_PIXEL)),
      .rd_addr (addr_calc),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff     <= 1'b1;
         clear_addr_ff   <= '0;
         shadow_valid_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (push_valid && s1_end_ff) begin
            shadow_valid_ff <= 1'b1;
         end
         if (s1_advance) begin
            s1_valid_ff <= take;
         end
      end
      if (take) begin
         s1_end_ff      <= (req_port.kind == drdr_pkg::IN_END);
         s1_addr_ff     <= addr_calc;
         s1_argb_ff     <= req_port.pixel_argb;
         s1_row_ff      <= req_port.row;
         s1_fwd_ff      <= s1_valid_ff && !s1_end_ff && (s1_addr_ff == addr_calc);
         s1_fwd_data_ff <= s1_argb_ff;
      end
   end

endmodule

`default_nettype wire

[src/drdr_fifo.sv]
// ----------------------------------------------------------------------------
// Work queue
// Small register FIFO between the front end and the refresh engine.
// ----------------------------------------------------------------------------
`default_nettype none

module drdr_fifo #(
   parameter int DEPTH = drdr_pkg::QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire drdr_pkg::queue_entry_type push_entry,
   output logic                           full,
   input  wire logic                      pop,
   output logic                           head_valid,
   output drdr_pkg::queue_entry_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   drdr_pkg::queue_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[src/drdr_back.sv]
// ----------------------------------------------------------------------------
// Refresh engine
// Drives writes out, tracks dirty rows, scans them at end of draw.
// ----------------------------------------------------------------------------
`default_nettype none

module drdr_back #(
   parameter int SCREEN_HEIGHT = drdr_pkg::SCREEN_HEIGHT_DEF,
   parameter int MAX_BANDS     = drdr_pkg::MAX_BANDS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         head_valid,
   input  wire drdr_pkg::queue_entry_type    head,
   output logic                              pop,
   input  wire logic [drdr_pkg::THR_W-1:0]   threshold,
   drdr_rsp_if.source                        rsp_port
);

   localparam int RC_W  = $clog2(SCREEN_HEIGHT + 2);
   localparam int RI_W  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam int NB_W  = $clog2(MAX_BANDS + 1);
   localparam int BI_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int CMP_W = (RC_W > drdr_pkg::THR_W) ? RC_W : drdr_pkg::THR_W;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_EMIT} state_type;

   state_type                         state_ff;
   logic [RC_W-1:0]                   scan_row_ff;
   logic [RC_W-1:0]                   count_ff;
   logic                              in_run_ff;
   logic [RC_W-1:0]                   start_ff;
   logic [NB_W-1:0]                   nb_ff;
   logic                              overflow_ff;
   logic [RC_W-1:0]                   run_first_ff [MAX_BANDS];
   logic [RC_W-1:0]                   band_len_ff [MAX_BANDS];
   logic [BI_W-1:0]                   emit_idx_ff;
   logic                              win_known_ff;
   logic [drdr_pkg::ROW_W-1:0]        win_top_ff;
   logic [drdr_pkg::ROW_W-1:0]        win_bot_ff;
   logic                              rsp_valid_ff;
   drdr_pkg::out_kind_type            rsp_kind_ff;
   logic [drdr_pkg::FB_ADDR_W-1:0]    rsp_addr_ff;
   logic [drdr_pkg::PIX565_W-1:0]     rsp_pix_ff;
   logic [drdr_pkg::ROW_W-1:0]        rsp_first_ff;
   logic [drdr_pkg::COUNT_W-1:0]      rsp_count_ff;
   logic                              rsp_nw_ff;
   logic                              rsp_last_ff;

   logic                              out_free;
   logic                              scan_issue;
   logic                              scan_dirty;
   logic                              dirty_q;
   logic                              dirty_wr_en;
   logic [RI_W-1:0]                   dirty_wr_addr;
   logic                              dirty_wr_data;
   logic                              go_full;
   logic                              emit;
   logic                              emit_refresh;
   drdr_pkg::out_kind_type            e_kind;
   logic [drdr_pkg::ROW_W-1:0]        e_top;
   logic [drdr_pkg::ROW_W-1:0]        e_bot;
   logic [drdr_pkg::COUNT_W-1:0]      e_count;
   logic                              e_last;
   logic                              e_nw;
   logic                              emit_done;

   assign out_free   = !rsp_valid_ff || rsp_port.ready;
   // Row scan_row_ff is read and cleared; the row before it comes back from the RAM.
   assign scan_issue = (state_ff == ST_SCAN) && (scan_row_ff < RC_W'(SCREEN_HEIGHT));
   assign scan_dirty = (scan_row_ff != '0) && (scan_row_ff <= RC_W'(SCREEN_HEIGHT))
                     && dirty_q;
   assign go_full    = overflow_ff || (CMP_W'(count_ff) >= CMP_W'(threshold));

   always_comb begin
      pop          = 1'b0;
      emit         = 1'b0;
      emit_refresh = 1'b0;
      emit_done    = 1'b0;
      e_kind       = drdr_pkg::OUT_WRITE;
      e_top        = '0;
      e_bot        = drdr_pkg::ROW_W'(SCREEN_HEIGHT - 1);
      e_count      = drdr_pkg::COUNT_W'(SCREEN_HEIGHT);
      e_last       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (!head.is_end) begin
                  pop  = out_free;
                  emit = out_free;
               end else if (!head.shadow_valid) begin
                  pop          = out_free;
                  emit         = out_free;
                  emit_refresh = 1'b1;
                  e_kind       = drdr_pkg::OUT_FULL;
               end else begin
                  pop = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (count_ff == '0) begin
               emit_done = 1'b1;
            end else if (go_full) begin
               emit         = out_free;
               emit_refresh = 1'b1;
               emit_done    = out_free;
               e_kind       = drdr_pkg::OUT_FULL;
            end else begin
               emit         = out_free;
               emit_refresh = 1'b1;
               e_kind       = drdr_pkg::OUT_BAND;
               e_top        = drdr_pkg::ROW_W'(run_first_ff[emit_idx_ff]);
               e_bot        = drdr_pkg::ROW_W'(run_first_ff[emit_idx_ff]
                                             + band_len_ff[emit_idx_ff] - 1'b1);
               e_count      = drdr_pkg::COUNT_W'(band_len_ff[emit_idx_ff]);
               e_last       = (NB_W'(emit_idx_ff) == nb_ff - 1'b1);
               emit_done    = out_free && e_last;
            end
         end
         default: begin
         end
      endcase
   end

   // Dirty map port: clear sweep after reset, mark on writes, clear during scan.
   always_comb begin
      dirty_wr_en   = 1'b0;
      dirty_wr_addr = scan_row_ff[RI_W-1:0];
      dirty_wr_data = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            dirty_wr_en = 1'b1;
         end
         ST_IDLE: begin
            dirty_wr_en   = pop && !head.is_end && head.shadow_valid;
            dirty_wr_addr = head.row[RI_W-1:0];
            dirty_wr_data = 1'b1;
         end
         ST_SCAN: begin
            dirty_wr_en = scan_issue;
         end
         default: begin
         end
      endcase
   end

   drdr_ram #(
      .WIDTH (1),
      .DEPTH (SCREEN_HEIGHT)
   ) u_dirty (
      .clock   (clock),
      .wr_en   (dirty_wr_en),
      .wr_addr (dirty_wr_addr),
      .wr_data (dirty_wr_data),
      .rd_en   (scan_issue),
      .rd_addr (scan_row_ff[RI_W-1:0]),
      .rd_data (dirty_q)
   );

   assign e_nw = !win_known_ff || (e_top != win_top_ff) || (e_bot != win_bot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_row_ff  <= '0;
         win_known_ff <= 1'b0;
         win_top_ff   <= '0;
         win_bot_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (emit && emit_refresh) begin
            win_known_ff <= 1'b1;
            win_top_ff   <= e_top;
            win_bot_ff   <= e_bot;
         end
         case (state_ff)
            ST_CLEAR: begin
               scan_row_ff <= scan_row_ff + 1'b1;
               if (scan_row_ff == RC_W'(SCREEN_HEIGHT - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop && head.is_end && head.shadow_valid) begin
                  state_ff    <= ST_SCAN;
                  scan_row_ff <= '0;
                  count_ff    <= '0;
                  in_run_ff   <= 1'b0;
                  nb_ff       <= '0;
                  overflow_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               // Classify row scan_row_ff-1 and close runs on a clean row.
               if (scan_dirty) begin
                  count_ff <= count_ff + 1'b1;
                  if (!in_run_ff) begin
                     in_run_ff <= 1'b1;
                     start_ff  <= scan_row_ff - 1'b1;
                  end
               end else if (in_run_ff) begin
                  in_run_ff <= 1'b0;
                  if (nb_ff == NB_W'(MAX_BANDS)) begin
                     overflow_ff <= 1'b1;
                  end else begin
                     run_first_ff[nb_ff[BI_W-1:0]] <= start_ff;
                     band_len_ff[nb_ff[BI_W-1:0]]  <= scan_row_ff - 1'b1 - start_ff;
                     nb_ff                         <= nb_ff + 1'b1;
                  end
               end
               scan_row_ff <= scan_row_ff + 1'b1;
               if (scan_row_ff == RC_W'(SCREEN_HEIGHT + 1)) begin
                  state_ff    <= ST_EMIT;
                  emit_idx_ff <= '0;
               end
            end
            ST_EMIT: begin
               if (emit_done) begin
                  state_ff <= ST_IDLE;
               end else if (emit) begin
                  emit_idx_ff <= emit_idx_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (emit) begin
         rsp_kind_ff  <= e_kind;
         rsp_last_ff  <= e_last;
         if (emit_refresh) begin
            rsp_addr_ff  <= '0;
            rsp_pix_ff   <= '0;
            rsp_first_ff <= e_top;
            rsp_count_ff <= e_count;
            rsp_nw_ff    <= e_nw;
         end else begin
            rsp_addr_ff  <= head.fb_address;
            rsp_pix_ff   <= head.pixel565;
            rsp_first_ff <= '0;
            rsp_count_ff <= '0;
            rsp_nw_ff    <= 1'b0;
         end
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.out_kind   = rsp_kind_ff;
   assign rsp_port.fb_address = rsp_addr_ff;
   assign rsp_port.pixel565   = rsp_pix_ff;
   assign rsp_port.first_row  = rsp_first_ff;
   assign rsp_port.row_count  = rsp_count_ff;
   assign rsp_port.new_window = rsp_nw_ff;
   assign rsp_port.last       = rsp_last_ff;

endmodule

`default_nettype wire
